/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both macros are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that cons holds in the same cycle as ante.
`define SIL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Checks that cons holds in the cycle after ante.
`define SIL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SIL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SIL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/sil_pkg.sv */
`default_nettype none

package sil_pkg;

  localparam int STAMP_W  = 32;
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd2;

  // Operation broadcast to every cell in the row.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_START,
    OP_FETCH
  } sil_op_t;

  // How the cursor mark moves on an insert.
  typedef enum logic [1:0] {
    CUR_SHIFT,
    CUR_HEAD,
    CUR_AFTER
  } sil_cmode_t;

  typedef struct packed {
    sil_op_t    op;
    sil_cmode_t cmode;
  } sil_ctrl_t;

  // Status that a cell hands on to its right-hand neighbour and to the top level.
  typedef struct packed {
    logic valid;
    logic mark;
    logic take;
    logic ins;
    logic hit;
    logic below;
  } sil_link_t;

endpackage

`default_nettype wire

/* hw/rtl/sil_cell.sv */
`default_nettype none

module sil_cell #(
  parameter int KW = 32,
  parameter int HW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head,
  input  wire sil_pkg::sil_ctrl_t ctrl,
  input  wire logic [KW-1:0]     new_key,
  input  wire logic [HW-1:0]     new_handle,
  input  wire logic [KW-1:0]     prev_key,
  input  wire logic [HW-1:0]     prev_handle,
  input  wire sil_pkg::sil_link_t prev,
  output logic [KW-1:0]          key,
  output logic [HW-1:0]          handle,
  output sil_pkg::sil_link_t     link,
  output logic                   past,
  output logic [HW-1:0]          hsel
);
  import sil_pkg::*;

  logic          valid;
  logic          mark;
  logic          valid_next;
  logic          mark_next;
  logic [KW-1:0] key_next;
  logic [HW-1:0] handle_next;
  logic          take;
  logic          hit;

  // An empty cell behaves as if it held a key above every other.
  always_comb begin
    take = ~valid | (key > new_key);
    hit  = mark & valid;
    link = '{valid: valid, mark: mark, take: take, ins: take & ~prev.take,
             hit: hit, below: valid & (key < new_key)};
    hsel = hit ? handle : '0;
  end

  always_comb begin
    valid_next  = valid;
    mark_next   = mark;
    key_next    = key;
    handle_next = handle;
    case (ctrl.op)
      OP_INSERT: begin
        valid_next = valid | prev.valid;
        if (prev.take) begin
          key_next    = prev_key;
          handle_next = prev_handle;
        end else if (take) begin
          key_next    = new_key;
          handle_next = new_handle;
        end
        case (ctrl.cmode)
          CUR_HEAD:  mark_next = head;
          CUR_AFTER: mark_next = prev.ins;
          default:   mark_next = prev.take ? prev.mark : (mark & ~take);
        endcase
      end
      OP_START: mark_next = head;
      OP_FETCH: mark_next = prev.hit | (mark & ~valid);
      default: ;
    endcase
    past = mark_next & ~valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= head;
    end else begin
      valid <= valid_next;
      mark  <= mark_next;
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    handle <= handle_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/sorted_insert_list_with_scan.sv */
// Sorted table of (stamp, handle) entries with a scan cursor.
// Requests arrive on req_valid/req_stall with kind, stamp and handle; kind
// selects an insert, a scan start or a fetch of the next entry. Every request
// gives exactly one response on rsp_valid/rsp_stall carrying item_handle,
// item_valid, scan_done and full_refused.
// Each request is handled by a row of CAPACITY cells: every cell compares its
// key with the incoming stamp and either holds, takes the new entry or takes
// its left neighbour's entry, so the insert shift happens in parallel. The
// response appears in the response register in the cycle after the request
// is accepted, and a new request may be accepted every cycle unless stalled.
// The response register is the only buffering: while a response is waiting and
// the receiver holds rsp_stall high, req_stall is raised and the table is frozen.
// Reset empties the table and puts the cursor at the end of the (empty) table.
// An insert into a full table is refused and flagged, and nothing changes.
`default_nettype none
`include "assert_macros.svh"

module sorted_insert_list_with_scan #(
  parameter int CAPACITY    = 64,
  parameter int KEY_BITS    = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [sil_pkg::KIND_W-1:0]    kind,
  input  wire logic [sil_pkg::STAMP_W-1:0]   stamp,
  input  wire logic [sil_pkg::HANDLE_W-1:0]  handle,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic [sil_pkg::HANDLE_W-1:0]       item_handle,
  output logic                               item_valid,
  output logic                               scan_done,
  output logic                               full_refused
);
  import sil_pkg::*;

  // Stored widths: the request fields are masked to the parameter widths.
  localparam int KW = (KEY_BITS < STAMP_W) ? KEY_BITS : STAMP_W;
  localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  logic              accept;
  logic              full;
  logic              empty;
  logic              front;
  logic              beyond_last;
  logic              refused;
  sil_ctrl_t         ctrl;
  logic [KW-1:0]     new_key;
  logic [HW-1:0]     new_handle;

  sil_link_t         link [CAPACITY];
  sil_link_t         prev_link [CAPACITY];
  logic [KW-1:0]     cell_key [CAPACITY];
  logic [HW-1:0]     cell_handle [CAPACITY];
  logic [KW-1:0]     prev_key [CAPACITY];
  logic [HW-1:0]     prev_handle [CAPACITY];
  logic [HW-1:0]     hsel [CAPACITY];
  logic [CAPACITY-1:0] past_vec;
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] mark_vec;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] below_vec;

  // The cursor may also sit one place past the last cell when the table is full.
  logic              mark_end;
  logic              mark_end_next;
  logic [HW-1:0]     hsel_or;
  logic              scan_done_next;

  assign new_key    = stamp[KW-1:0];
  assign new_handle = handle[HW-1:0];

  // The response register is freed in the same cycle that it is read.
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  // The occupied cells form a prefix of the row, so the last cell tells fullness.
  assign full  = valid_vec[CAPACITY-1];
  assign empty = ~valid_vec[0];
  // Stamp strictly below the first key: the new entry goes in front.
  assign front = valid_vec[0] & link[0].take;
  // Stamp strictly above the last key: the new entry is appended.
  assign beyond_last = |(valid_vec & ~{1'b0, valid_vec[CAPACITY-1:1]} & below_vec);

  always_comb begin
    ctrl    = '{op: OP_NONE, cmode: CUR_SHIFT};
    refused = 1'b0;
    if (accept) begin
      unique case (kind)
        KIND_INSERT: begin
          if (full) begin
            refused = 1'b1;
          end else begin
            ctrl.op = OP_INSERT;
            if (empty) begin
              ctrl.cmode = CUR_HEAD;
            end else if (!front && !beyond_last) begin
              // A middle insert, ties included, puts the cursor just past it.
              ctrl.cmode = CUR_AFTER;
            end
          end
        end
        KIND_START: ctrl.op = OP_START;
        KIND_FETCH: ctrl.op = OP_FETCH;
        default: ;
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_link[i]   = '{valid: 1'b1, default: 1'b0};
        assign prev_key[i]    = '0;
        assign prev_handle[i] = '0;
      end else begin : g_body
        assign prev_link[i]   = link[i-1];
        assign prev_key[i]    = cell_key[i-1];
        assign prev_handle[i] = cell_handle[i-1];
      end

      sil_cell #(
        .KW (KW),
        .HW (HW)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .head        (i == 0),
        .ctrl        (ctrl),
        .new_key     (new_key),
        .new_handle  (new_handle),
        .prev_key    (prev_key[i]),
        .prev_handle (prev_handle[i]),
        .prev        (prev_link[i]),
        .key         (cell_key[i]),
        .handle      (cell_handle[i]),
        .link        (link[i]),
        .past        (past_vec[i]),
        .hsel        (hsel[i])
      );

      assign valid_vec[i] = link[i].valid;
      assign mark_vec[i]  = link[i].mark;
      assign hit_vec[i]   = link[i].hit;
      assign below_vec[i] = link[i].below;
    end
  endgenerate

  // Only the cell under the cursor drives a non-zero handle.
  always_comb begin
    hsel_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      hsel_or = hsel_or | hsel[k];
    end
  end

  // The end position behaves as one more, always empty, cell.
  always_comb begin
    mark_end_next = mark_end;
    case (ctrl.op)
      OP_INSERT: begin
        case (ctrl.cmode)
          CUR_HEAD:  mark_end_next = 1'b0;
          CUR_AFTER: mark_end_next = link[CAPACITY-1].ins;
          default:   mark_end_next = link[CAPACITY-1].take ? mark_vec[CAPACITY-1] : mark_end;
        endcase
      end
      OP_START: mark_end_next = 1'b0;
      OP_FETCH: mark_end_next = mark_end | hit_vec[CAPACITY-1];
      default: ;
    endcase
    scan_done_next = (|past_vec) | mark_end_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_end  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      mark_end <= mark_end_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_handle  <= (ctrl.op == OP_FETCH) ? HANDLE_W'(hsel_or) : '0;
      item_valid   <= (ctrl.op == OP_FETCH) & (|hit_vec);
      scan_done    <= scan_done_next;
      full_refused <= refused;
    end
  end

  // Occupied cells always form an unbroken run from the head of the row.
  `SIL_ASSERT_IMP(a_valid_prefix, clk, rst, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  // The cursor sits at exactly one place, counting the end position.
  `SIL_ASSERT_IMP(a_cursor_onehot, clk, rst, 1'b1, $onehot({mark_end, mark_vec}))
  // An accepted insert always leaves a non-empty table behind.
  `SIL_ASSERT_NEXT(a_insert_fills, clk, rst, ctrl.op == OP_INSERT, valid_vec[0])
  // A refused insert leaves the occupancy unchanged.
  `SIL_ASSERT_NEXT(a_refused_holds, clk, rst, refused, $stable(valid_vec))

endmodule

`default_nettype wire

/* tb/sorted_insert_list_with_scan_tb.sv */
`timescale 1ns / 100ps

module sorted_insert_list_with_scan_tb;
  import sil_pkg::*;

  // Table depth used for both the block and the predictor.
  localparam int unsigned DEPTH = 64;

  // The fourth kind code is unused by the block and must leave the table alone.
  localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;

  // Stimulus and flow control knobs.
  localparam int unsigned RANDOM_ITEMS   = 950;
  localparam int unsigned STALL_PCT      = 16;
  localparam int unsigned QUIET_FROM     = 300;
  localparam int unsigned QUIET_TO       = 450;
  localparam int unsigned HOLD_AT        = 600;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One response of the block, in port order.
  typedef struct packed {
    logic [HANDLE_W-1:0] hnd;
    logic                hit;
    logic                done;
    logic                refused;
  } reply_t;

  // One row of stimulus. Where typed is set, want holds the hand-written answer.
  typedef struct {
    logic [KIND_W-1:0]   k;
    logic [STAMP_W-1:0]  s;
    logic [HANDLE_W-1:0] h;
    bit                  typed;
    reply_t              want;
  } request_t;

  // Answers that can be read straight off the behaviour.
  localparam reply_t REPLY_AT_END  = '{hnd: '0, hit: 1'b0, done: 1'b1, refused: 1'b0};
  localparam reply_t REPLY_ON_ROW  = '{hnd: '0, hit: 1'b0, done: 1'b0, refused: 1'b0};
  localparam reply_t REPLY_TOP_HIT = '{hnd: 16'hFFFF, hit: 1'b1, done: 1'b1, refused: 1'b0};

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic [KIND_W-1:0]   kind;
  logic [STAMP_W-1:0]  stamp;
  logic [HANDLE_W-1:0] handle;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [HANDLE_W-1:0] item_handle;
  logic                item_valid;
  logic                scan_done;
  logic                full_refused;

  sorted_insert_list_with_scan #(
    .CAPACITY    (DEPTH),
    .KEY_BITS    (STAMP_W),
    .HANDLE_BITS (HANDLE_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .kind         (kind),
    .stamp        (stamp),
    .handle       (handle),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .item_handle  (item_handle),
    .item_valid   (item_valid),
    .scan_done    (scan_done),
    .full_refused (full_refused)
  );

  // Predictor state: a sorted copy of the table and the scan cursor. The cursor
  // runs from 0 to row_count, and row_count itself means the scan is at the end.
  logic [STAMP_W-1:0]  row_key [DEPTH];
  logic [HANDLE_W-1:0] row_hnd [DEPTH];
  int unsigned         row_count;
  int unsigned         cursor;

  request_t    stim_rows[$];
  reply_t      expected_replies[$];
  int unsigned requests_sent;
  int unsigned mismatches         = 0;
  int unsigned refusals_seen      = 0;
  int unsigned entries_fetched    = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned idle_cycles        = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the predicted table and returns the response it
  // should produce. An insert lands after every key that is less than or equal
  // to its own, so ties keep their arrival order and none is lost.
  function automatic reply_t table_step(input logic [KIND_W-1:0] k,
                                        input logic [STAMP_W-1:0] s,
                                        input logic [HANDLE_W-1:0] h);
    reply_t      r;
    int unsigned pos;
    int unsigned next_cursor;
    int unsigned i;
    r = '0;
    case (k)
      KIND_INSERT: begin
        if (row_count >= DEPTH) begin
          r.refused = 1'b1;
        end else if (row_count == 0) begin
          // The first entry also becomes the cursor position.
          row_key[0] = s;
          row_hnd[0] = h;
          row_count  = 1;
          cursor     = 0;
        end else begin
          pos = 0;
          while (pos < row_count && row_key[pos] <= s) pos++;
          // A new head pushes the cursor's entry along by one; a new tail
          // leaves the cursor on its entry (or keeps it at the end); anything
          // in between, ties included, parks the cursor just past the new entry.
          if (s < row_key[0])
            next_cursor = cursor + 1;
          else if (s > row_key[row_count-1])
            next_cursor = (cursor >= row_count) ? row_count + 1 : cursor;
          else
            next_cursor = pos + 1;
          for (i = row_count; i > pos; i--) begin
            row_key[i] = row_key[i-1];
            row_hnd[i] = row_hnd[i-1];
          end
          row_key[pos] = s;
          row_hnd[pos] = h;
          row_count++;
          cursor = (next_cursor > row_count) ? row_count : next_cursor;
        end
      end
      KIND_START: cursor = 0;
      KIND_FETCH: begin
        // A fetch at the end returns nothing and leaves the cursor where it is.
        if (cursor < row_count) begin
          r.hnd = row_hnd[cursor];
          r.hit = 1'b1;
          cursor++;
        end
      end
      default: ;
    endcase
    r.done = (cursor >= row_count);
    return r;
  endfunction

  function automatic void add_row(input logic [KIND_W-1:0] k,
                                  input logic [STAMP_W-1:0] s,
                                  input logic [HANDLE_W-1:0] h,
                                  input bit typed, input reply_t want);
    request_t row;
    row.k     = k;
    row.s     = s;
    row.h     = h;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  task automatic note_mismatch(input string what, input reply_t want, input reply_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display({"%0t %s: expected handle %h hit %b done %b refused %b,",
                " got handle %h hit %b done %b refused %b"},
               $time, what, want.hnd, want.hit, want.done, want.refused,
               got.hnd, got.hit, got.done, got.refused);
  endtask

  // Request side: builds the stimulus, drives it and records what each
  // accepted request should answer.
  initial begin
    int unsigned            n_directed;
    int unsigned            n_live;
    int unsigned            n_inserts;
    int unsigned            burst;
    int unsigned            run_len;
    int unsigned            sel;
    int unsigned            idx;
    logic [STAMP_W-1:0]     key;
    logic [STAMP_W-1:0]     used_keys[$];
    request_t               row;
    reply_t                 want;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    kind      <= KIND_IDLE;
    stamp     <= '0;
    handle    <= '0;
    row_count     = 0;
    cursor        = 0;
    requests_sent = 0;

    // Directed part. Rows with a typed answer are those whose result is plain
    // from the state: an empty table, the first entry and a fetch at the end.
    add_row(KIND_FETCH,  32'h1234_5678, 16'h9ABC, 1'b1, REPLY_AT_END);
    add_row(KIND_START,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, REPLY_AT_END);
    add_row(KIND_IDLE,   32'h0000_0000, 16'h0000, 1'b1, REPLY_AT_END);
    add_row(KIND_INSERT, 32'h8000_0000, 16'hFFFF, 1'b1, REPLY_ON_ROW);
    add_row(KIND_FETCH,  32'h0000_0000, 16'h0000, 1'b1, REPLY_TOP_HIT);
    // New head, new tail, a tie at the middle, a plain middle insert, then ties at the tail and the head.
    add_row(KIND_INSERT, 32'h0000_0000, 16'h0000, 1'b0, '0);
    add_row(KIND_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 1'b0, '0);
    add_row(KIND_START,  32'h0000_0000, 16'h0000, 1'b0, '0);
    add_row(KIND_FETCH,  32'h0000_0000, 16'h0000, 1'b0, '0);
    add_row(KIND_INSERT, 32'h8000_0000, 16'h5555, 1'b0, '0);
    add_row(KIND_INSERT, 32'h4000_0000, 16'h1234, 1'b0, '0);
    add_row(KIND_INSERT, 32'hFFFF_FFFF, 16'h0001, 1'b0, '0);
    add_row(KIND_INSERT, 32'h0000_0000, 16'h0002, 1'b0, '0);
    add_row(KIND_START,  32'h5A5A_5A5A, 16'hA5A5, 1'b0, '0);
    repeat (7) add_row(KIND_FETCH, 32'hA5A5_A5A5, 16'h5A5A, 1'b0, '0);
    add_row(KIND_FETCH,  32'h0000_0000, 16'h0000, 1'b1, REPLY_AT_END);
    add_row(KIND_IDLE,   32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0);
    add_row(KIND_INSERT, 32'h0000_0001, 16'hC3C3, 1'b0, '0);
    n_directed = stim_rows.size();

    // Random part, built as episodes: bursts of inserts, scans that start and
    // then walk a stretch of the table (now and then right off its end), and a
    // little noise. Once past the middle, inserts are pushed until the table
    // is certain to have filled, so later inserts are refused.
    n_live    = 0;
    n_inserts = 0;
    while (n_live < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35 || (n_live > RANDOM_ITEMS / 2 && n_inserts < 90)) begin
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          sel = $urandom_range(0, 99);
          if (sel < 12)
            key = '0;
          else if (sel < 24)
            key = '1;
          else if (sel < 50 && used_keys.size() != 0)
            key = used_keys[$urandom_range(0, used_keys.size() - 1)];
          else if (sel < 70)
            key = $urandom_range(0, 255);
          else
            key = $urandom;
          used_keys.push_back(key);
          add_row(KIND_INSERT, key, HANDLE_W'($urandom_range(0, 65535)), 1'b0, '0);
          n_inserts++;
          n_live++;
        end
      end else if (sel < 85) begin
        add_row(KIND_START, $urandom, HANDLE_W'($urandom_range(0, 65535)), 1'b0, '0);
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                              : $urandom_range(1, 12);
        repeat (run_len)
          add_row(KIND_FETCH, $urandom, HANDLE_W'($urandom_range(0, 65535)), 1'b0, '0);
        n_live += run_len + 1;
      end else if (sel < 94) begin
        add_row(KIND_FETCH, $urandom, HANDLE_W'($urandom_range(0, 65535)), 1'b0, '0);
        n_live++;
      end else begin
        add_row(KIND_IDLE, $urandom, HANDLE_W'($urandom_range(0, 65535)), 1'b0, '0);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Walk the whole table of requests. Valid drops only for a random idle
    // cycle; otherwise the next request follows straight on, so valid stays
    // high across back-to-back requests.
    for (idx = 0; idx < stim_rows.size(); idx++) begin
      row = stim_rows[idx];
      while (!(requests_sent >= QUIET_FROM && requests_sent < QUIET_TO) &&
             $urandom_range(0, 99) < STALL_PCT) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      req_valid <= 1'b1;
      kind      <= row.k;
      stamp     <= row.s;
      handle    <= row.h;
      @(posedge clk);
      while (req_stall) @(posedge clk);
      want = table_step(row.k, row.s, row.h);
      if (row.typed) want = row.want;
      expected_replies.push_back(want);
      requests_sent++;
    end
    req_valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (%0d directed), %0d entries held, %0d inserts refused as full",
             requests_sent, n_directed, row_count, refusals_seen);
    $display("%0d entries fetched, request side held off for %0d cycles",
             entries_fetched, input_stall_cycles);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Response side: random stall cycles, a quiet stretch with none, and one
  // long hold-off while requests keep coming so that the block backs up.
  initial begin
    bit held_off;
    held_off = 1'b0;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && requests_sent >= HOLD_AT) begin
        held_off = 1'b1;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_stall <= !(requests_sent >= QUIET_FROM && requests_sent < QUIET_TO) &&
                   ($urandom_range(0, 99) < STALL_PCT);
      @(posedge clk);
    end
  end

  // Every accepted response is matched against the oldest outstanding answer.
  always @(posedge clk) begin : check_responses
    reply_t got;
    reply_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = {item_handle, item_valid, scan_done, full_refused};
      if (got.refused) refusals_seen++;
      if (got.hit) entries_fetched++;
      if (expected_replies.size() == 0) begin
        note_mismatch("response with no request outstanding", '0, got);
      end else begin
        want = expected_replies.pop_front();
        if (got.hnd != want.hnd || got.hit != want.hit ||
            got.done != want.done || got.refused != want.refused)
          note_mismatch("response mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles where neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                 idle_cycles, expected_replies.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
    if (!rst && req_valid && req_stall) input_stall_cycles <= input_stall_cycles + 1;
  end

endmodule
